// File: rtl/blr_pkg.sv
package blr_pkg;

    // configuration register widths and indexes
    localparam int DIM_BITS  = 11;
    localparam int ADDR_BITS = 22;

    localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd750;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd400;

    // request codes
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // per-pixel flags carried down the pipeline
    typedef struct packed {
        logic last;
        logic no_line;
    } t_pix_flags;

endpackage

// File: rtl/blr_step.sv
module blr_step
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_load,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output t_pix_flags            o_flags
);

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 2;

    // line state
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [EW-1:0]         r_err, n_err;
    logic [COORD_BITS-1:0] r_steps, n_steps;
    logic [COORD_BITS-1:0] r_maj, n_maj;
    logic [COORD_BITS-1:0] r_mnr, n_mnr;
    logic                  r_sx_neg, n_sx_neg;
    logic                  r_sy_neg, n_sy_neg;
    logic                  r_x_major, n_x_major;
    logic                  r_active, n_active;

    // pixel output register
    logic                  r_pix_valid;
    logic [COORD_BITS-1:0] r_pix_x, n_pix_x;
    logic [COORD_BITS-1:0] r_pix_y, n_pix_y;
    t_pix_flags            r_pix_flags, n_pix_flags;

    // start setup terms
    logic [DW-1:0]         dx_s, dy_s, dx_n, dy_n;
    logic [COORD_BITS-1:0] adx, ady, st_maj, st_mnr;
    logic                  st_x_major;

    // advance terms
    logic                  minor_step;
    logic [EW-1:0]         err_inc;
    logic [COORD_BITS-1:0] x_step, y_step;

    always_comb begin
        // signed differences, one bit wider so they never overflow
        dx_s = {i_x_end[COORD_BITS-1], i_x_end} - {i_x_start[COORD_BITS-1], i_x_start};
        dy_s = {i_y_end[COORD_BITS-1], i_y_end} - {i_y_start[COORD_BITS-1], i_y_start};
        dx_n = -dx_s;
        dy_n = -dy_s;
        adx  = dx_s[DW-1] ? dx_n[COORD_BITS-1:0] : dx_s[COORD_BITS-1:0];
        ady  = dy_s[DW-1] ? dy_n[COORD_BITS-1:0] : dy_s[COORD_BITS-1:0];
        st_x_major = adx > ady;
        st_maj = st_x_major ? adx : ady;
        st_mnr = st_x_major ? ady : adx;

        // error term update for one step
        minor_step = ~r_err[EW-1];
        err_inc = minor_step ? ({1'b0, r_mnr, 1'b0} - {1'b0, r_maj, 1'b0})
                             : {1'b0, r_mnr, 1'b0};
        x_step  = r_sx_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        y_step  = r_sy_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;

        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_err     = r_err;
        n_steps   = r_steps;
        n_maj     = r_maj;
        n_mnr     = r_mnr;
        n_sx_neg  = r_sx_neg;
        n_sy_neg  = r_sy_neg;
        n_x_major = r_x_major;
        n_active  = r_active;

        n_pix_x = '0;
        n_pix_y = '0;
        n_pix_flags = '{last: 1'b0, no_line: 1'b0};

        if (i_req_type == REQ_START) begin
            n_cur_x   = i_x_start;
            n_cur_y   = i_y_start;
            n_maj     = st_maj;
            n_mnr     = st_mnr;
            n_err     = {1'b0, st_mnr, 1'b0} - {2'b00, st_maj};
            n_steps   = st_maj;
            n_sx_neg  = dx_s[DW-1];
            n_sy_neg  = dy_s[DW-1];
            n_x_major = st_x_major;
            n_active  = st_maj != '0;
            n_pix_x   = i_x_start;
            n_pix_y   = i_y_start;
            n_pix_flags.last = st_maj == '0;
        end else if (!r_active) begin
            n_pix_flags.no_line = 1'b1;
        end else begin
            n_err = r_err + err_inc;
            if (r_x_major || minor_step) begin
                n_cur_x = x_step;
            end
            if (!r_x_major || minor_step) begin
                n_cur_y = y_step;
            end
            n_steps  = r_steps - 1'b1;
            n_active = r_steps != {{(COORD_BITS-1){1'b0}}, 1'b1};
            n_pix_x  = n_cur_x;
            n_pix_y  = n_cur_y;
            n_pix_flags.last = !n_active;
        end
    end

    // state update on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_err     <= '0;
            r_steps   <= '0;
            r_maj     <= '0;
            r_mnr     <= '0;
            r_sx_neg  <= 1'b0;
            r_sy_neg  <= 1'b0;
            r_x_major <= 1'b0;
            r_active  <= 1'b0;
        end else if (i_accept) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_err     <= n_err;
            r_steps   <= n_steps;
            r_maj     <= n_maj;
            r_mnr     <= n_mnr;
            r_sx_neg  <= n_sx_neg;
            r_sy_neg  <= n_sy_neg;
            r_x_major <= n_x_major;
            r_active  <= n_active;
        end
    end

    // pixel register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (i_load) begin
            r_pix_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pix_x     <= n_pix_x;
            r_pix_y     <= n_pix_y;
            r_pix_flags <= n_pix_flags;
        end
    end

    assign o_valid = r_pix_valid;
    assign o_x     = r_pix_x;
    assign o_y     = r_pix_y;
    assign o_flags = r_pix_flags;

endmodule

// File: rtl/blr_addr.sv
module blr_addr
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [DIM_BITS-1:0]   i_width,
    input  logic [DIM_BITS-1:0]   i_height,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  t_pix_flags            i_flags,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic [ADDR_BITS-1:0]  o_address,
    output logic                  o_write,
    output t_pix_flags            o_flags
);

    localparam int PROD_BITS = COORD_BITS + DIM_BITS + 1;
    localparam int SUM_BITS  = (PROD_BITS + 1 > ADDR_BITS + 1) ? PROD_BITS + 1 : ADDR_BITS + 1;
    localparam int LIM_BITS  = 2 * DIM_BITS;

    logic                  en_mul, en_out;

    // multiply stage
    logic                  r_mul_valid;
    logic [PROD_BITS-1:0]  r_prod;
    logic [COORD_BITS-1:0] r_mul_x, r_mul_y;
    t_pix_flags            r_mul_flags;
    logic signed [PROD_BITS-1:0] n_prod;

    // output stage
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [ADDR_BITS-1:0]  r_out_addr, n_out_addr;
    logic                  r_out_write, n_out_write;
    t_pix_flags            r_out_flags;

    // framebuffer size, refreshed from the registers every cycle
    logic [LIM_BITS-1:0]   r_limit;
    logic [SUM_BITS-1:0]   sum;

    // each stage moves when the one after it is free or draining
    assign en_out  = !r_out_valid || i_ready;
    assign en_mul  = !r_mul_valid || en_out;
    assign o_ready = en_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_BITS'(WIDTH_RESET) * LIM_BITS'(HEIGHT_RESET);
        end else begin
            r_limit <= LIM_BITS'(i_width) * LIM_BITS'(i_height);
        end
    end

    // row offset y * width
    assign n_prod = $signed(i_y) * $signed({1'b0, i_width});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (en_mul) begin
            r_mul_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_mul && i_valid) begin
            r_prod      <= n_prod;
            r_mul_x     <= i_x;
            r_mul_y     <= i_y;
            r_mul_flags <= i_flags;
        end
    end

    // address and clip against [0, width*height)
    always_comb begin
        sum = SUM_BITS'($signed(r_prod)) + SUM_BITS'($signed(r_mul_x));
        n_out_write = !r_mul_flags.no_line && !sum[SUM_BITS-1]
                      && (sum < SUM_BITS'(r_limit));
        n_out_addr  = n_out_write ? sum[ADDR_BITS-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_mul_valid) begin
            r_out_x     <= r_mul_x;
            r_out_y     <= r_mul_y;
            r_out_addr  <= n_out_addr;
            r_out_write <= n_out_write;
            r_out_flags <= r_mul_flags;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_x       = r_out_x;
    assign o_y       = r_out_y;
    assign o_address = r_out_addr;
    assign o_write   = r_out_write;
    assign o_flags   = r_out_flags;

endmodule

// File: rtl/bresenham_line_rasterizer_unit.sv
// a result passes through the pixel register, the multiply stage and the output stage
// throughput: one request beat per cycle unless the output stalls, one result beat per request
// the line state advances in the cycle of acceptance, so starts and advances run back to back
// reset (synchronous, active low) empties the pipeline, drops any active line
// and loads screen width 750 and height 400
module bresenham_line_rasterizer_unit
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [DIM_BITS-1:0]   i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [ADDR_BITS-1:0]  o_pixel_address,
    output logic                  o_pixel_write,
    output logic                  o_last_pixel,
    output logic                  o_no_line
);

    logic [DIM_BITS-1:0]   r_width, r_height;
    logic                  pix_valid, pix_ready, in_accept, pix_load;
    logic [COORD_BITS-1:0] pix_x, pix_y;
    t_pix_flags            pix_flags, out_flags;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pixel register frees when empty or when its beat moves on
    assign pix_load   = !pix_valid || pix_ready;
    assign o_in_ready = pix_load;
    assign in_accept  = i_in_valid && pix_load;

    blr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_load     (pix_load),
        .i_req_type (i_req_type),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_valid    (pix_valid),
        .o_x        (pix_x),
        .o_y        (pix_y),
        .o_flags    (pix_flags)
    );

    blr_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_valid   (pix_valid),
        .o_ready   (pix_ready),
        .i_x       (pix_x),
        .i_y       (pix_y),
        .i_flags   (pix_flags),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_x       (o_pixel_x),
        .o_y       (o_pixel_y),
        .o_address (o_pixel_address),
        .o_write   (o_pixel_write),
        .o_flags   (out_flags)
    );

    assign o_last_pixel = out_flags.last;
    assign o_no_line    = out_flags.no_line;

endmodule
